>>> rtl/psh_pkg.sv
// ----------------------------------------------------------------------------
// psh_pkg
// Shared types, codes and constants of the point slice height binning block.
// ----------------------------------------------------------------------------
package psh_pkg;

    localparam int MAX_CELLS_X_DEF = 128;
    localparam int MAX_CELLS_Y_DEF = 128;
    localparam int MAX_SLICES_DEF  = 16;

    localparam int COORD_W = 24;
    localparam int DIM_W   = 12;
    localparam int DIV_NW  = 26;
    localparam int DIV_DW  = 17;
    localparam int TOP_W   = 27;
    localparam int POS_W   = 28;
    localparam int PADDR_W = 5;

    localparam logic [COORD_W-1:0] EMPTY_LOW  = 24'h800000;
    localparam logic [COORD_W-1:0] EMPTY_HIGH = 24'h7FFFFF;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_STORED     = 3'd0,
        STS_OUT_OF_MAP = 3'd1,
        STS_INVALID    = 3'd2,
        STS_READ_DONE  = 3'd3,
        STS_CLEARED    = 3'd4,
        STS_READ_OOB   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_CELL_SIZE   = 3'd2,
        REG_MAP_WIDTH   = 3'd3,
        REG_MAP_HEIGHT  = 3'd4,
        REG_SLICE_COUNT = 3'd5,
        REG_SLICE_BASE  = 3'd6,
        REG_SLICE_STEP  = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_CHECK,
        S_SLICE,
        S_RD_WAIT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [15:0]               cell_size;
        logic [7:0]                map_width;
        logic [7:0]                map_height;
        logic [4:0]                slice_count;
        logic signed [COORD_W-1:0] slice_base;
        logic [15:0]               slice_step;
    } cfg_t;

    typedef struct packed {
        logic    load;
        logic    div_start;
        logic    slice_init;
        logic    slice_run;
        logic    rd_issue;
        logic    clr_run;
        logic    out_load;
        status_t code;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic point_valid;
        logic div_done;
        logic out_of_map;
        logic slice_done;
        logic read_oob;
        logic clr_last;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic               gk;
        logic [COORD_W-1:0] g;
        logic               ck;
        logic [COORD_W-1:0] c;
    } cell_word_t;

endpackage

>>> rtl/psh_regs.sv
// ----------------------------------------------------------------------------
// psh_regs
// APB configuration registers with read back.
// ----------------------------------------------------------------------------
module psh_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [psh_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output psh_pkg::cfg_t                cfg
);
    import psh_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_x    <= '0;
            cfg_reg.center_y    <= '0;
            cfg_reg.cell_size   <= 16'd100;
            cfg_reg.map_width   <= 8'd128;
            cfg_reg.map_height  <= 8'd128;
            cfg_reg.slice_count <= 5'd16;
            cfg_reg.slice_base  <= '0;
            cfg_reg.slice_step  <= 16'd200;
        end else if (wr_en) begin
            case (idx)
                REG_CENTER_X:    cfg_reg.center_x    <= pwdata[23:0];
                REG_CENTER_Y:    cfg_reg.center_y    <= pwdata[23:0];
                REG_CELL_SIZE:   cfg_reg.cell_size   <= pwdata[15:0];
                REG_MAP_WIDTH:   cfg_reg.map_width   <= pwdata[7:0];
                REG_MAP_HEIGHT:  cfg_reg.map_height  <= pwdata[7:0];
                REG_SLICE_COUNT: cfg_reg.slice_count <= pwdata[4:0];
                REG_SLICE_BASE:  cfg_reg.slice_base  <= pwdata[23:0];
                REG_SLICE_STEP:  cfg_reg.slice_step  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CENTER_X:    prdata = {{8{cfg_reg.center_x[23]}}, cfg_reg.center_x};
            REG_CENTER_Y:    prdata = {{8{cfg_reg.center_y[23]}}, cfg_reg.center_y};
            REG_CELL_SIZE:   prdata = {16'd0, cfg_reg.cell_size};
            REG_MAP_WIDTH:   prdata = {24'd0, cfg_reg.map_width};
            REG_MAP_HEIGHT:  prdata = {24'd0, cfg_reg.map_height};
            REG_SLICE_COUNT: prdata = {27'd0, cfg_reg.slice_count};
            REG_SLICE_BASE:  prdata = {{8{cfg_reg.slice_base[23]}}, cfg_reg.slice_base};
            REG_SLICE_STEP:  prdata = {16'd0, cfg_reg.slice_step};
            default:         prdata = '0;
        endcase
    end

endmodule

>>> rtl/psh_div.sv
// ----------------------------------------------------------------------------
// psh_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psh_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [psh_pkg::DIV_NW-1:0]  dividend,
    input  logic [psh_pkg::DIV_DW-1:0]  divisor,
    output logic [psh_pkg::DIV_NW-1:0]  quotient,
    output logic                        done
);
    import psh_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW);

    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [DIV_DW:0]   trial;
    logic              ge;

    assign trial    = {rem_reg, quo_reg[DIV_NW-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign quotient = quo_reg;
    assign done     = !busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NW - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            // shift one dividend bit in, subtract where it fits
            rem_reg <= ge ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], ge};
        end
    end

endmodule

>>> rtl/psh_dp.sv
// ----------------------------------------------------------------------------
// psh_dp
// Datapath: request capture, cell index division, slice read-modify-write,
// map memory with clear sweep, and the result register.
// ----------------------------------------------------------------------------
module psh_dp #(
    parameter int MAX_CELLS_X = psh_pkg::MAX_CELLS_X_DEF,
    parameter int MAX_CELLS_Y = psh_pkg::MAX_CELLS_Y_DEF,
    parameter int MAX_SLICES  = psh_pkg::MAX_SLICES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  psh_pkg::cfg_t                       cfg,
    input  psh_pkg::cmd_t                       cmd,
    output psh_pkg::stat_t                      stat,
    input  logic [1:0]                          s_operation,
    input  logic signed [psh_pkg::COORD_W-1:0]  s_point_x,
    input  logic signed [psh_pkg::COORD_W-1:0]  s_point_y,
    input  logic signed [psh_pkg::COORD_W-1:0]  s_point_z,
    input  logic                                s_point_valid,
    input  logic [6:0]                          s_read_col,
    input  logic [6:0]                          s_read_row,
    input  logic [3:0]                          s_read_slice,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_status,
    output logic signed [psh_pkg::COORD_W-1:0]  m_ground_height,
    output logic signed [psh_pkg::COORD_W-1:0]  m_ceiling_height,
    output logic                                m_ground_known,
    output logic                                m_ceiling_known
);
    import psh_pkg::*;

    localparam int PLANE = MAX_CELLS_X * MAX_CELLS_Y;
    localparam int DEPTH = PLANE * MAX_SLICES;
    localparam int AW    = $clog2(DEPTH);

    localparam cell_word_t EMPTY_WORD = '{gk: 1'b0, g: EMPTY_LOW, ck: 1'b0, c: EMPTY_HIGH};

    // captured request
    op_t                 op_reg;
    logic [COORD_W-1:0]  px_reg, py_reg, pz_reg;
    logic                pv_reg;
    logic [6:0]          rcol_reg, rrow_reg;
    logic [3:0]          rslice_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= op_t'(s_operation);
            px_reg     <= s_point_x;
            py_reg     <= s_point_y;
            pz_reg     <= s_point_z;
            pv_reg     <= s_point_valid;
            rcol_reg   <= s_read_col;
            rrow_reg   <= s_read_row;
            rslice_reg <= s_read_slice;
        end
    end

    // dimensions in use, clamped to the storage size
    logic [DIM_W-1:0] w_dim, h_dim, ns_dim;
    assign w_dim  = (DIM_W'(cfg.map_width) > DIM_W'(MAX_CELLS_X)) ?
                    DIM_W'(MAX_CELLS_X) : DIM_W'(cfg.map_width);
    assign h_dim  = (DIM_W'(cfg.map_height) > DIM_W'(MAX_CELLS_Y)) ?
                    DIM_W'(MAX_CELLS_Y) : DIM_W'(cfg.map_height);
    assign ns_dim = (DIM_W'(cfg.slice_count) > DIM_W'(MAX_SLICES)) ?
                    DIM_W'(MAX_SLICES) : DIM_W'(cfg.slice_count);

    // round(d / r), halves away from zero: (2|d| + r) / (2r), sign restored
    logic [15:0]       cell_res;
    logic [COORD_W:0]  dx, dy, magx, magy;
    logic [DIV_NW-1:0] numx, numy, qx, qy;
    logic [DIV_DW-1:0] den;
    logic              negx_reg, negy_reg, done_x, done_y;

    assign cell_res = (cfg.cell_size == 16'd0) ? 16'd1 : cfg.cell_size;
    assign dx   = {px_reg[COORD_W-1], px_reg} - {cfg.center_x[COORD_W-1], cfg.center_x};
    assign dy   = {py_reg[COORD_W-1], py_reg} - {cfg.center_y[COORD_W-1], cfg.center_y};
    assign magx = dx[COORD_W] ? ((COORD_W+1)'(0) - dx) : dx;
    assign magy = dy[COORD_W] ? ((COORD_W+1)'(0) - dy) : dy;
    assign numx = {magx, 1'b0} + DIV_NW'(cell_res);
    assign numy = {magy, 1'b0} + DIV_NW'(cell_res);
    assign den  = {cell_res, 1'b0};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            negx_reg <= dx[COORD_W];
            negy_reg <= dy[COORD_W];
        end
    end

    psh_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (numx),
        .divisor  (den),
        .quotient (qx),
        .done     (done_x)
    );

    psh_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (numy),
        .divisor  (den),
        .quotient (qy),
        .done     (done_y)
    );

    logic [POS_W-1:0] ixs, iys;
    logic             oom;
    logic [AW-1:0]    base_ins, rd_addr;
    logic             read_oob;

    assign ixs = (negx_reg ? (POS_W'(0) - POS_W'(qx)) : POS_W'(qx)) + POS_W'(w_dim >> 1);
    assign iys = (negy_reg ? (POS_W'(0) - POS_W'(qy)) : POS_W'(qy)) + POS_W'(h_dim >> 1);
    assign oom = ixs[POS_W-1] || (ixs >= POS_W'(w_dim)) ||
                 iys[POS_W-1] || (iys >= POS_W'(h_dim));

    assign base_ins = AW'(32'(iys[DIM_W-1:0]) * 32'(MAX_CELLS_X) + 32'(ixs[DIM_W-1:0]));
    assign rd_addr  = AW'(32'(rslice_reg) * 32'(PLANE) + 32'(rrow_reg) * 32'(MAX_CELLS_X)
                      + 32'(rcol_reg));
    assign read_oob = (DIM_W'(rcol_reg) >= w_dim) || (DIM_W'(rrow_reg) >= h_dim) ||
                      (DIM_W'(rslice_reg) >= ns_dim);

    // slice loop: read slice k while writing back slice k-1
    logic [AW-1:0]           addr_reg, wb_addr_reg;
    logic signed [TOP_W-1:0] top_reg, wb_top_reg;
    logic [DIM_W-1:0]        scnt_reg;
    logic                    wb_v_reg;
    logic                    issue;

    assign issue = cmd.slice_run && (scnt_reg < ns_dim);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scnt_reg <= '0;
            wb_v_reg <= 1'b0;
        end else begin
            wb_v_reg <= issue;
            if (cmd.slice_init) begin
                scnt_reg <= '0;
            end else if (issue) begin
                scnt_reg <= scnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.slice_init) begin
            addr_reg <= base_ins;
            top_reg  <= {{(TOP_W-COORD_W){cfg.slice_base[COORD_W-1]}}, cfg.slice_base};
        end else if (issue) begin
            addr_reg <= addr_reg + AW'(PLANE);
            top_reg  <= top_reg + TOP_W'(cfg.slice_step);
        end
        wb_addr_reg <= addr_reg;
        wb_top_reg  <= top_reg;
    end

    // map memory
    cell_word_t mem [DEPTH];
    cell_word_t mem_q, wb_word, mem_wd;
    logic [AW-1:0] mem_wa, mem_ra, clr_addr_reg;
    logic          mem_we, mem_re, clr_last;
    logic signed [TOP_W-1:0] pz_ext;
    logic          pz_low;

    assign pz_ext = {{(TOP_W-COORD_W){pz_reg[COORD_W-1]}}, pz_reg};
    assign pz_low = pz_ext <= wb_top_reg;

    always_comb begin
        wb_word = mem_q;
        if (pz_low) begin
            wb_word.gk = 1'b1;
            if ($signed(pz_reg) > $signed(mem_q.g)) begin
                wb_word.g = pz_reg;
            end
        end else begin
            wb_word.ck = 1'b1;
            if ($signed(pz_reg) < $signed(mem_q.c)) begin
                wb_word.c = pz_reg;
            end
        end
    end

    assign clr_last = clr_addr_reg == AW'(DEPTH - 1);
    assign mem_we   = cmd.clr_run || wb_v_reg;
    assign mem_wa   = cmd.clr_run ? clr_addr_reg : wb_addr_reg;
    assign mem_wd   = cmd.clr_run ? EMPTY_WORD : wb_word;
    assign mem_re   = issue || cmd.rd_issue;
    assign mem_ra   = cmd.rd_issue ? rd_addr : addr_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            mem_q <= mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_run) begin
            clr_addr_reg <= clr_last ? '0 : clr_addr_reg + 1'b1;
        end
    end

    // result register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status <= cmd.code;
            if (cmd.code == STS_READ_DONE) begin
                m_ground_height  <= mem_q.g;
                m_ceiling_height <= mem_q.c;
                m_ground_known   <= mem_q.gk;
                m_ceiling_known  <= mem_q.ck;
            end else begin
                m_ground_height  <= '0;
                m_ceiling_height <= '0;
                m_ground_known   <= 1'b0;
                m_ceiling_known  <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        stat.op          = op_reg;
        stat.point_valid = pv_reg;
        stat.div_done    = done_x && done_y;
        stat.out_of_map  = oom;
        stat.slice_done  = (scnt_reg >= ns_dim) && !wb_v_reg;
        stat.read_oob    = read_oob;
        stat.clr_last    = clr_last;
        stat.out_free    = !m_valid_reg || m_ready;
    end

`ifndef SYNTHESIS
    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clr_run && wb_v_reg))
        else $error("clear sweep and slice write-back collide");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.out_load))
        else $error("result valid without a load");

    a_read_not_in_slice: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd_issue && cmd.slice_run))
        else $error("cell read issued during slice loop");
`endif

endmodule

>>> rtl/psh_ctrl.sv
// ----------------------------------------------------------------------------
// psh_ctrl
// Controller: sequences insert, read and clear requests and the clear sweep
// after reset.
// ----------------------------------------------------------------------------
module psh_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  psh_pkg::stat_t  stat,
    output psh_pkg::cmd_t   cmd
);
    import psh_pkg::*;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    clr_op_reg, clr_op_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            code_reg   <= STS_STORED;
            clr_op_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            code_reg   <= code_next;
            clr_op_reg <= clr_op_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        code_next   = code_reg;
        clr_op_next = clr_op_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clr_last) begin
                    if (clr_op_reg) begin
                        state_next = S_RESP;
                        code_next  = STS_CLEARED;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.op)
                    OP_INSERT: begin
                        if (!stat.point_valid) begin
                            state_next = S_RESP;
                            code_next  = STS_INVALID;
                        end else begin
                            state_next = S_DIV;
                        end
                    end
                    OP_READ: begin
                        if (stat.read_oob) begin
                            state_next = S_RESP;
                            code_next  = STS_READ_OOB;
                        end else begin
                            state_next = S_RD_WAIT;
                        end
                    end
                    OP_CLEAR: begin
                        state_next  = S_CLEAR;
                        clr_op_next = 1'b1;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_DIV: begin
                if (stat.div_done) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.out_of_map) begin
                    state_next = S_RESP;
                    code_next  = STS_OUT_OF_MAP;
                end else begin
                    state_next = S_SLICE;
                end
            end
            S_SLICE: begin
                if (stat.slice_done) begin
                    state_next = S_RESP;
                    code_next  = STS_STORED;
                end
            end
            S_RD_WAIT: begin
                state_next = S_RESP;
                code_next  = STS_READ_DONE;
            end
            S_RESP: begin
                // hold until the result register frees up
                if (stat.out_free) begin
                    state_next  = S_IDLE;
                    clr_op_next = 1'b0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = state_reg == S_IDLE;
        cmd.load       = (state_reg == S_IDLE) && s_valid;
        cmd.div_start  = (state_reg == S_DECODE) && (stat.op == OP_INSERT) &&
                         stat.point_valid;
        cmd.rd_issue   = (state_reg == S_DECODE) && (stat.op == OP_READ) &&
                         !stat.read_oob;
        cmd.slice_init = (state_reg == S_CHECK) && !stat.out_of_map;
        cmd.slice_run  = state_reg == S_SLICE;
        cmd.clr_run    = state_reg == S_CLEAR;
        cmd.out_load   = (state_reg == S_RESP) && stat.out_free;
        cmd.code       = code_reg;
    end

endmodule

>>> rtl/point_slice_height_binning.sv
// ----------------------------------------------------------------------------
// point_slice_height_binning
// Bins 3D points into a sliced 2D height grid; reads and clears cells.
// ----------------------------------------------------------------------------
// An insert runs 26 bit-serial cell index division steps, then the slice
// read-modify-write over the ns slices in use; a read does one map read; a
// clear sweeps MAX_CELLS_X*MAX_CELLS_Y*MAX_SLICES entries, one per cycle.
// One request in work at a time; s_ready rises in the same cycle as m_valid.
// Reset (aresetn low, synchronous) restores the registers and then sweeps
// the whole map empty, 262144 entries at default size, with s_ready low.
module point_slice_height_binning #(
    parameter int MAX_CELLS_X = psh_pkg::MAX_CELLS_X_DEF,
    parameter int MAX_CELLS_Y = psh_pkg::MAX_CELLS_Y_DEF,
    parameter int MAX_SLICES  = psh_pkg::MAX_SLICES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [psh_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic signed [psh_pkg::COORD_W-1:0]  s_point_x,
    input  logic signed [psh_pkg::COORD_W-1:0]  s_point_y,
    input  logic signed [psh_pkg::COORD_W-1:0]  s_point_z,
    input  logic                                s_point_valid,
    input  logic [6:0]                          s_read_col,
    input  logic [6:0]                          s_read_row,
    input  logic [3:0]                          s_read_slice,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_status,
    output logic signed [psh_pkg::COORD_W-1:0]  m_ground_height,
    output logic signed [psh_pkg::COORD_W-1:0]  m_ceiling_height,
    output logic                                m_ground_known,
    output logic                                m_ceiling_known
);
    import psh_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    psh_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    psh_dp #(
        .MAX_CELLS_X (MAX_CELLS_X),
        .MAX_CELLS_Y (MAX_CELLS_Y),
        .MAX_SLICES  (MAX_SLICES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .cmd              (cmd),
        .stat             (stat),
        .s_operation      (s_operation),
        .s_point_x        (s_point_x),
        .s_point_y        (s_point_y),
        .s_point_z        (s_point_z),
        .s_point_valid    (s_point_valid),
        .s_read_col       (s_read_col),
        .s_read_row       (s_read_row),
        .s_read_slice     (s_read_slice),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_ground_height  (m_ground_height),
        .m_ceiling_height (m_ceiling_height),
        .m_ground_known   (m_ground_known),
        .m_ceiling_known  (m_ceiling_known)
    );

endmodule
